// ===== sv/lgbi_pkg.sv =====
// ============================================================================
// Log-grid bilinear interpolation package
// Shared constants, field widths, codes and helper functions for the
// log-grid bilinear interpolation lookup block.
// ============================================================================
package lgbi_pkg;

    // Table geometry and stored time width.
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 10;
    localparam int TIME_BITS   = 32;

    // A stored entry keeps at most 32 bits of the loaded time.
    localparam int ENTRY_W  = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = 4;
    localparam int RCNT_W   = 5;

    // Field widths.
    localparam int SIZE_W   = 40;
    localparam int LEN_W    = 10;
    localparam int FRAC_W   = 16;
    localparam int WGT_W    = FRAC_W + 1;
    localparam int EST_W    = 48;
    localparam int MULA_W   = 48;
    localparam int PROD_W   = MULA_W + WGT_W;
    localparam int ACC_W    = MULA_W + SIZE_W + 1;
    localparam int LOG_W    = 6;

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(1 << FRAC_W);

    // Division by three through a reciprocal: floor(u / 3) = (u * RECIP3) >> 20
    // holds for every u below 2^19.
    localparam int U_W          = 18;
    localparam int RECIP3_SHIFT = 20;
    localparam int RECIP3_W     = 19;
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((1 << RECIP3_SHIFT) + 2) / 3);

    // Smallest message size, the size of row zero.
    localparam int SIZE_LOG_BASE = 6;
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1 << SIZE_LOG_BASE);

    // Request kinds.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ROWS    = 1'b0;
    localparam logic CFG_COLUMNS = 1'b1;

    // Position of the highest set bit (zero for inputs of zero or one).
    function automatic logic [LOG_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
        logic [LOG_W-1:0] n;
        n = '0;
        for (int i = 1; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                n = LOG_W'(i);
            end
        end
        return n;
    endfunction

    // Flat address of one table entry.
    function automatic logic [ADDR_W-1:0] table_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row * MAX_COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ===== sv/log_grid_bilinear_interp.sv =====
// ============================================================================
// Log-grid bilinear interpolation lookup
// Keeps a table of measured times on a grid of message sizes (64 * 4^row)
// and block lengths (2^column) and answers estimate requests by bilinear
// interpolation, or by scaling the last row past the end of the table.
// ============================================================================

// A load writes one table entry, if in range, in the cycle it is accepted and
// gives no result. An estimate request goes through preparation and multiply
// steps (a longer sequence beyond the last row) before its result reaches the
// output register; with no rows loaded it goes from preparation straight to
// output with an invalid result. The next request is accepted the cycle
// after the result is registered, even while that result still waits to be
// taken. The steps are set by the single-port table memory, read once per
// cycle for the four (or two) surrounding entries, and by the one shared
// 48x17 multiplier that does every blend and scaling step in turn. The table
// has no reset: every entry that an estimate touches must be loaded first.
module log_grid_bilinear_interp
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] entry_row, [7:4] entry_column, [39:8] entry_time,
    // [79:40] message_bytes, [89:80] block_length, [95:90] zero
    input  logic [95:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [47:0] estimated_time
    output logic [47:0] m_axis_tdata,
    // [0] estimate_valid
    output logic        m_axis_tuser,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import lgbi_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] STEP_LAST_NORMAL = 4'd7;
    localparam logic [3:0] STEP_LAST_BEYOND = 4'd8;

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [RCNT_W-1:0] rows_in_use_reg;
    logic [COL_W-1:0]  columns_in_use_reg;
    logic              out_valid_reg;

    // Payload registers.
    logic [SIZE_W-1:0] size_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SIZE_W-1:0] dist_reg;
    logic [LOG_W-1:0]  ylog_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic [COL_W-1:0]  xi1_reg, xi2_reg;
    logic [ROW_W-1:0]  row_a_reg, row_b_reg;
    logic              beyond_reg;
    logic [LOG_W-1:0]  shamt_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [63:0]       hold_reg;
    logic [MULA_W-1:0] f1_reg, f2_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              res_flag_reg;
    logic [EST_W-1:0]  res_time_reg;
    logic              out_flag_reg;
    logic [EST_W-1:0]  out_time_reg;

    // Table memory.
    logic [ENTRY_W-1:0] time_table [DEPTH];
    logic [ENTRY_W-1:0] mem_q;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;

    logic in_accept;
    logic out_free;
    logic last_step;

    // Request fields.
    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;
    logic [ENTRY_W-1:0] in_time;

    // Preparation results.
    logic [SIZE_W-1:0] sz_c;
    logic [LOG_W-1:0]  slog_c;
    logic [LOG_W-1:0]  yexp_c;
    logic [RCNT_W-1:0] yi1_c, yi2_c;
    logic [SIZE_W-1:0] dist_c;
    logic [LEN_W-1:0]  len_c;
    logic [COL_W-1:0]  xl_c;
    logic [LEN_W-1:0]  dl_c;
    logic [FRAC_W-1:0] fx0_c;
    logic [COL_W-1:0]  xi2a_c, xi2_c, xi1_c, cols_c;
    logic [RCNT_W-1:0] rows_c;
    logic [ROW_W-1:0]  last_c;

    // Datapath.
    logic [U_W-1:0]            u_c;
    logic [U_W+RECIP3_W-1:0]   fy_prod;
    logic [WGT_W-1:0]          w0_c, wsel_c;
    logic [MULA_W-1:0]         mul_a;
    logic [WGT_W-1:0]          mul_b;
    logic [ROW_W-1:0]          rd_row;
    logic [COL_W-1:0]          rd_col;
    logic [64:0]               blend_sum;
    logic [32:0]               blend_res;
    logic [ACC_W-1:0]          round_c;
    logic [ACC_W-1:0]          scaled_c;
    logic [EST_W-1:0]          beyond_res;

    assign in_row  = s_axis_tdata[3:0];
    assign in_col  = s_axis_tdata[7:4];
    assign in_time = s_axis_tdata[8 +: ENTRY_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign last_step     = (step_reg == (beyond_reg ? STEP_LAST_BEYOND : STEP_LAST_NORMAL));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_time_reg;
    assign m_axis_tuser  = out_flag_reg;

    // ---------------- Preparation: bracket the query on the grid ----------------
    always_comb
    begin
        sz_c   = (size_reg < SIZE_MIN) ? SIZE_MIN : size_reg;
        slog_c = floor_log2(sz_c);
        yi1_c  = RCNT_W'((slog_c - LOG_W'(SIZE_LOG_BASE)) >> 1);
        yexp_c = LOG_W'({yi1_c, 1'b0}) + LOG_W'(SIZE_LOG_BASE);
        dist_c = sz_c - (SIZE_W'(1) << yexp_c);
        yi2_c  = (dist_c == '0) ? yi1_c : yi1_c + RCNT_W'(1);

        len_c  = (len_reg == '0) ? LEN_W'(1) : len_reg;
        xl_c   = COL_W'(floor_log2(SIZE_W'(len_c)));
        dl_c   = len_c - (LEN_W'(1) << xl_c);
        fx0_c  = FRAC_W'({dl_c, {FRAC_W{1'b0}}} >> xl_c);
        xi2a_c = (dl_c == '0) ? xl_c : xl_c + COL_W'(1);

        if (columns_in_use_reg == '0)
        begin
            cols_c = COL_W'(1);
        end
        else if (columns_in_use_reg > COL_W'(MAX_COLUMNS))
        begin
            cols_c = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_c = columns_in_use_reg;
        end

        xi2_c = (xi2a_c >= cols_c) ? cols_c - COL_W'(1) : xi2a_c;
        xi1_c = (xl_c > xi2_c) ? xi2_c : xl_c;

        rows_c = (rows_in_use_reg > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : rows_in_use_reg;
        last_c = ROW_W'(rows_c - RCNT_W'(1));
    end

    // ---------------- Shared multiplier operands ----------------
    assign w0_c   = ONE_Q16 - WGT_W'(fx_reg);
    // Each entry read comes back registered in mem_q; even entries take the
    // left column weight, odd entries the right one.
    assign wsel_c = step_reg[0] ? w0_c : WGT_W'(fx_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (!beyond_reg)
        begin
            if (step_reg >= 4'd1 && step_reg <= 4'd4)
            begin
                mul_a = MULA_W'(mem_q);
                mul_b = wsel_c;
            end
            else if (step_reg == 4'd5)
            begin
                mul_a = f1_reg;
                mul_b = ONE_Q16 - WGT_W'(fy_reg);
            end
            else if (step_reg == 4'd6)
            begin
                mul_a = f2_reg;
                mul_b = WGT_W'(fy_reg);
            end
        end
        else
        begin
            if (step_reg == 4'd1 || step_reg == 4'd2)
            begin
                mul_a = MULA_W'(mem_q);
                mul_b = wsel_c;
            end
            else if (step_reg == 4'd4)
            begin
                mul_a = f1_reg;
                mul_b = size_reg[16:0];
            end
            else if (step_reg == 4'd5)
            begin
                mul_a = f1_reg;
                mul_b = size_reg[33:17];
            end
            else if (step_reg == 4'd6)
            begin
                mul_a = f1_reg;
                mul_b = WGT_W'(size_reg[39:34]);
            end
        end
    end

    // fy = floor(((size - y1) << 16) / (3 * y1)), with y1 a power of two.
    assign u_c     = U_W'({dist_reg, {FRAC_W{1'b0}}} >> ylog_reg);
    assign fy_prod = u_c * RECIP3;

    assign blend_sum  = {1'b0, hold_reg} + 65'(prod_reg[63:0]);
    assign blend_res  = 33'(blend_sum[63:32]) + 33'(blend_sum[31]);
    assign round_c    = ACC_W'(1) << (shamt_reg - LOG_W'(1));
    assign scaled_c   = acc_reg >> shamt_reg;
    assign beyond_res = (|scaled_c[ACC_W-1:EST_W]) ? {EST_W{1'b1}} : scaled_c[EST_W-1:0];

    // ---------------- Table memory, one port ----------------
    assign rd_row   = step_reg[1] ? row_b_reg : row_a_reg;
    assign rd_col   = step_reg[0] ? xi2_reg : xi1_reg;
    assign mem_we   = in_accept && (s_axis_tuser == OP_LOAD)
                      && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLUMNS);
    assign mem_addr = mem_we ? table_addr(in_row, in_col) : table_addr(rd_row, rd_col);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_table[mem_addr] <= in_time;
        end
        else
        begin
            mem_q <= time_table[mem_addr];
        end
    end

    // ---------------- Sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && s_axis_tuser == OP_QUERY)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                step_next  = '0;
                state_next = (rows_c == '0) ? ST_OUT : ST_RUN;
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= '0;
            rows_in_use_reg    <= '0;
            columns_in_use_reg <= COL_W'(MAX_COLUMNS);
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ROWS:    rows_in_use_reg    <= cfg_data[RCNT_W-1:0];
                    CFG_COLUMNS: columns_in_use_reg <= cfg_data[COL_W-1:0];
                    default:     rows_in_use_reg    <= rows_in_use_reg;
                endcase
            end

            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- Datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_accept && s_axis_tuser == OP_QUERY)
        begin
            size_reg <= s_axis_tdata[79:40];
            len_reg  <= s_axis_tdata[89:80];
        end

        if (state_reg == ST_PREP)
        begin
            size_reg   <= sz_c;
            dist_reg   <= dist_c;
            ylog_reg   <= yexp_c;
            xi1_reg    <= xi1_c;
            xi2_reg    <= xi2_c;
            fx_reg     <= (xi1_c == xi2_c) ? '0 : fx0_c;
            beyond_reg <= ({1'b0, yi2_c} >= {1'b0, rows_c});
            row_a_reg  <= ({1'b0, yi2_c} >= {1'b0, rows_c}) ? last_c : ROW_W'(yi1_c);
            row_b_reg  <= ROW_W'(yi2_c);
            shamt_reg  <= LOG_W'(FRAC_W + SIZE_LOG_BASE) + LOG_W'({last_c, 1'b0});
            res_flag_reg <= 1'b0;
            res_time_reg <= '0;
        end

        if (state_reg == ST_RUN)
        begin
            prod_reg <= mul_a * mul_b;

            if (step_reg == 4'd0)
            begin
                fy_reg <= fy_prod[RECIP3_SHIFT +: FRAC_W];
            end

            // First product of each pair is held for the sum that follows.
            if (step_reg == 4'd2 || (!beyond_reg && (step_reg == 4'd4 || step_reg == 4'd6)))
            begin
                hold_reg <= 64'(prod_reg);
            end

            if (step_reg == 4'd3)
            begin
                f1_reg <= MULA_W'(hold_reg + 64'(prod_reg));
            end

            if (!beyond_reg && step_reg == 4'd5)
            begin
                f2_reg <= MULA_W'(hold_reg + 64'(prod_reg));
            end

            // Beyond the last row: base * size in slices of 17, 17 and 6 bits, with
            // the rounding half folded into the first one.
            if (beyond_reg)
            begin
                if (step_reg == 4'd5)
                begin
                    acc_reg <= ACC_W'(prod_reg) + round_c;
                end
                else if (step_reg == 4'd6)
                begin
                    acc_reg <= acc_reg + ACC_W'({prod_reg, 17'b0});
                end
                else if (step_reg == 4'd7)
                begin
                    acc_reg <= acc_reg + ACC_W'({prod_reg, 34'b0});
                end
            end

            if (last_step)
            begin
                res_flag_reg <= 1'b1;
                res_time_reg <= beyond_reg ? beyond_res : EST_W'(blend_res);
            end
        end

        if (state_reg == ST_OUT && out_free)
        begin
            out_flag_reg <= res_flag_reg;
            out_time_reg <= res_time_reg;
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Log-grid bilinear interpolation testbench
// Loads table entries and sends estimate requests while a local predictor of
// the table, the grid bracketing and the fixed-point blend works out every
// expected estimate. Each result is checked against the oldest expectation.
// The run steps through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgbi_pkg::*;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] etime;
        logic [39:0] msg_bytes;
        logic [9:0]  blk_len;
    } request_t;

    typedef struct packed {
        logic        valid;
        logic [47:0] value;
    } estimate_t;

    localparam logic [47:0] EST_MAX = '1;
    localparam logic [39:0] BYTES_MAX = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = OP_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ROWS;
    logic [4:0]  cfg_data = '0;

    log_grid_bilinear_interp DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: table contents and effective register values.
    logic [31:0] time_tbl [MAX_ROWS][MAX_COLUMNS];
    int          rows_eff = 0;
    int          cols_eff = MAX_COLUMNS;
    // Entries that some load has written, tracked when requests are generated.
    bit          loaded [MAX_ROWS][MAX_COLUMNS];

    request_t    pending_requests[$];
    estimate_t   expected_estimates[$];
    request_t    cur_req;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int top_bit(input logic [39:0] v);
        int n;
        n = 0;
        for (int i = 1; i < 40; i++)
        begin
            if (v[i])
            begin
                n = i;
            end
        end
        return n;
    endfunction

    // Finds the surrounding rows and columns of a query point and the UQ0.16
    // fractions; size and length are already raised to their minimums.
    function automatic void bracket(input logic [39:0] msg_size, input logic [9:0] blk,
                                    output bit past_end, output int ylo, output int yhi,
                                    output int xlo, output int xhi,
                                    output logic [16:0] fy, output logic [16:0] fx);
        logic [63:0] y1;
        int          lg;
        int          lenv;
        lg = top_bit(msg_size);
        ylo = (lg - 6) / 2;
        y1 = 64'd1 << (2 * ylo + 6);
        if (y1 == 64'(msg_size))
        begin
            yhi = ylo;
            fy = '0;
        end
        else
        begin
            yhi = ylo + 1;
            fy = 17'(((64'(msg_size) - y1) << 16) / (3 * y1));
        end
        lenv = blk;
        lg = top_bit(40'(blk));
        xlo = lg;
        if ((1 << lg) == lenv)
        begin
            xhi = xlo;
            fx = '0;
        end
        else
        begin
            xhi = xlo + 1;
            fx = 17'(((lenv - (1 << lg)) << 16) >> lg);
        end
        if (xhi >= cols_eff)
        begin
            xhi = cols_eff - 1;
        end
        if (xlo > xhi)
        begin
            xlo = xhi;
        end
        if (xlo == xhi)
        begin
            fx = '0;
        end
        past_end = (yhi >= rows_eff);
        if (past_end)
        begin
            ylo = rows_eff - 1;
            yhi = rows_eff - 1;
        end
    endfunction

    // Q.16 interpolation along one row.
    function automatic logic [63:0] row_mix(input int r, input int c1, input int c2,
                                            input logic [16:0] fx);
        return 64'(time_tbl[r][c1]) * (64'd65536 - 64'(fx)) + 64'(time_tbl[r][c2]) * 64'(fx);
    endfunction

    function automatic estimate_t predict_estimate(input logic [39:0] bytes_in,
                                                   input logic [9:0] len_in);
        estimate_t    e;
        logic [39:0]  msg_size;
        logic [9:0]   blk;
        bit           past_end;
        int           ylo, yhi, xlo, xhi, s;
        logic [16:0]  fy, fx;
        logic [127:0] f1, f2, acc;
        e = '0;
        if (rows_eff == 0)
        begin
            return e;
        end
        msg_size = (bytes_in < 40'd64) ? 40'd64 : bytes_in;
        blk = (len_in == '0) ? 10'd1 : len_in;
        bracket(msg_size, blk, past_end, ylo, yhi, xlo, xhi, fy, fx);
        f1 = 128'(row_mix(ylo, xlo, xhi, fx));
        if (past_end)
        begin
            // Scale the last row by size over that row's size, rounded half up.
            s = 16 + 6 + 2 * ylo;
            acc = (f1 * 128'(msg_size) + (128'd1 << (s - 1))) >> s;
        end
        else
        begin
            f2 = 128'(row_mix(yhi, xlo, xhi, fx));
            acc = f1 * (128'd65536 - 128'(fy)) + f2 * 128'(fy);
            acc = (acc >> 32) + 128'(acc[31]);
        end
        e.valid = 1'b1;
        e.value = (acc > 128'(EST_MAX)) ? EST_MAX : acc[47:0];
        return e;
    endfunction

    task automatic accept_request(input request_t q);
        if (q.opcode == OP_LOAD)
        begin
            if (q.col < MAX_COLUMNS)
            begin
                time_tbl[q.row][q.col] = q.etime;
            end
        end
        else
        begin
            expected_estimates.push_back(predict_estimate(q.msg_bytes, q.blk_len));
        end
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                accept_request(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, cur_req.blk_len, cur_req.msg_bytes, cur_req.etime,
                                     cur_req.col, cur_req.row};
                    s_axis_tuser <= cur_req.opcode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_estimates.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected, valid %0b time %0h",
                                              m_axis_tuser, m_axis_tdata));
                end
                else
                begin
                    e = expected_estimates.pop_front();
                    if (m_axis_tuser !== e.valid)
                    begin
                        report_mismatch($sformatf("estimate_valid %0b, expected %0b",
                                                  m_axis_tuser, e.valid));
                    end
                    if (m_axis_tdata !== e.value)
                    begin
                        report_mismatch($sformatf("estimated_time %0h, expected %0h",
                                                  m_axis_tdata, e.value));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic request_t random_request();
        request_t q;
        q.opcode = 1'($urandom);
        q.row = 4'($urandom);
        q.col = 4'($urandom);
        q.etime = $urandom;
        q.msg_bytes = 40'({$urandom, $urandom});
        q.blk_len = 10'($urandom);
        return q;
    endfunction

    task automatic queue_load(input int r, input int c, input logic [31:0] t);
        request_t q;
        q = random_request();
        q.opcode = OP_LOAD;
        q.row = 4'(r);
        q.col = 4'(c);
        q.etime = t;
        pending_requests.push_back(q);
        if (c < MAX_COLUMNS)
        begin
            loaded[r][c] = 1'b1;
        end
    endtask

    // Every entry that the estimate will read is loaded first.
    task automatic queue_query(input logic [39:0] bytes_in, input logic [9:0] len_in);
        request_t    q;
        bit          past_end;
        int          ylo, yhi, xlo, xhi, r, c;
        logic [16:0] fy, fx;
        if (rows_eff != 0)
        begin
            bracket((bytes_in < 40'd64) ? 40'd64 : bytes_in,
                    (len_in == '0) ? 10'd1 : len_in,
                    past_end, ylo, yhi, xlo, xhi, fy, fx);
            for (int i = 0; i < 4; i++)
            begin
                r = (i < 2) ? ylo : yhi;
                c = (i % 2 == 0) ? xlo : xhi;
                if (!loaded[r][c])
                begin
                    queue_load(r, c, $urandom);
                end
            end
        end
        q = random_request();
        q.opcode = OP_QUERY;
        q.msg_bytes = bytes_in;
        q.blk_len = len_in;
        pending_requests.push_back(q);
    endtask

    function automatic logic [39:0] random_bytes();
        int          e;
        logic [39:0] w;
        w = 40'({$urandom, $urandom});
        case ($urandom_range(9))
            0: return 40'($urandom_range(63));
            1: return 40'd64 << (2 * $urandom_range(16));
            2: return BYTES_MAX;
            3, 4, 5, 6:
            begin
                // Mostly inside the loaded rows or just past them.
                e = $urandom_range(6, 6 + 2 * rows_eff + 1);
                if (e > 39)
                begin
                    e = 39;
                end
            end
            default: e = $urandom_range(39);
        endcase
        return (40'd1 << e) | (w & ((40'd1 << e) - 40'd1));
    endfunction

    function automatic logic [9:0] random_length();
        case ($urandom_range(9))
            0: return '0;
            1: return 10'd1 << $urandom_range(9);
            2: return 10'($urandom_range(513, 1023));
            default: return 10'($urandom_range(1, 512));
        endcase
    endfunction

    task automatic write_config(input logic idx, input logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_ROWS)
        begin
            rows_eff = (val > 5'(MAX_ROWS)) ? MAX_ROWS : int'(val);
        end
        else
        begin
            cols_eff = (val[3:0] == '0) ? 1 :
                       (val[3:0] > 4'(MAX_COLUMNS)) ? MAX_COLUMNS : int'(val[3:0]);
        end
    endtask

    // Waits for both queues to drain and the request valid to drop, then
    // idles on before the registers change. The queues and the request
    // valid are sampled at the falling edge, after the driver has settled.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_estimates.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    int ph_rows [8] = '{1, 31, 3, 16, 0, 7, 16, 2};
    int ph_cols [8] = '{1, 15, 0, 10, 5, 20, 10, 10};
    int ph_send [8] = '{72, 0, 38, 0, 72, 0, 38, 0};
    int ph_recv [8] = '{0, 72, 38, 0, 0, 72, 38, 0};
    int ph_count [8] = '{130, 130, 130, 130, 40, 130, 130, 130};

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset setting no rows are loaded, so estimates are invalid.
        queue_load(0, 0, 32'hFFFF_FFFF);
        queue_query(40'd0, 10'd0);
        queue_query(BYTES_MAX, 10'h3FF);
        wait_idle();

        write_config(CFG_ROWS, 5'd16);
        write_config(CFG_COLUMNS, 5'd10);
        queue_load(15, 9, 32'hFFFF_FFFF);
        queue_load(0, 1, 32'd0);
        queue_load(3, 12, $urandom);
        queue_load(15, 15, $urandom);
        queue_query(40'd0, 10'd0);
        queue_query(40'd63, 10'd2);
        queue_query(40'd64 << 30, 10'd512);
        queue_query(BYTES_MAX, 10'h3FF);
        queue_query(40'd100, 10'd3);
        queue_query(40'd1, 10'd1000);
        queue_query(40'd5000, 10'd700);
        wait_idle();

        // A single row with a full-scale entry drives the scaled estimate
        // into saturation.
        write_config(CFG_ROWS, 5'd1);
        write_config(CFG_COLUMNS, 5'd1);
        queue_query(BYTES_MAX, 10'd1);
        queue_query(40'd200, 10'd0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            write_config(CFG_ROWS, 5'(ph_rows[p]));
            write_config(CFG_COLUMNS, 5'(ph_cols[p]));
            send_idle_pct = ph_send[p];
            recv_stall_pct = ph_recv[p];
            for (int i = 0; i < ph_count[p]; i++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    queue_load($urandom_range(MAX_ROWS - 1), $urandom_range(15), $urandom);
                end
                else
                begin
                    queue_query(random_bytes(), random_length());
                end
            end
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_estimates.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
